/* rtl/flha_pkg.sv */
// ============================================================================
// flha_pkg
// Shared types, constants and helpers of the free-list heap allocator.
// ============================================================================
`default_nettype none

package flha_pkg;

    // Heap geometry
    localparam int HEAP_UNITS = 65536;
    localparam int UNIT_SHIFT = 4;          // 16-byte units
    localparam int MIN_GROWTH = 4096;
    localparam int LOOP_CAP   = 2 * HEAP_UNITS + 4;

    // Widths
    localparam int IDX_W  = 16;             // header memory index
    localparam int POS_W  = 17;             // list position, sentinel is 0
    localparam int NU_W   = 18;             // units requested incl. header
    localparam int STEP_W = 18;             // walk step counter
    localparam int SIZE_W = 21;             // request bytes

    localparam logic [POS_W-1:0]  HEAP_POS_MAX = POS_W'(HEAP_UNITS);
    localparam logic [NU_W-1:0]   MIN_GROW_NU  = NU_W'(MIN_GROWTH);
    localparam logic [STEP_W-1:0] STEP_CAP     = STEP_W'(LOOP_CAP);

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Classified request handed from front to back
    typedef struct packed {
        logic             kind;
        logic [NU_W-1:0]  nunits;
        logic [IDX_W-1:0] bp;
    } req_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_FIRST,
        ST_A_CHECK,
        ST_A_SPLIT,
        ST_A_GROWN,
        ST_R_WALK,
        ST_R_B,
        ST_R_N,
        ST_R_P
    } state_t;

    // Position maps onto a header memory entry
    function automatic logic pos_valid(input logic [POS_W-1:0] pos);
        pos_valid = (pos != '0) && (pos <= HEAP_POS_MAX);
    endfunction

    function automatic logic [IDX_W-1:0] pos_idx(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] d;
        d       = pos - POS_W'(1);
        pos_idx = d[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/free_list_heap_allocator.sv */
// ============================================================================
// free_list_heap_allocator
// Next-fit heap allocator over 16-byte units with an address-ordered free list.
// ============================================================================
// A request (allocate or free) is taken when start is high and busy is low;
// up to two requests queue ahead of the list walker, and a request is
// registered in the queue before the walker takes it. Each request gives one
// result, shown for one cycle with done high; the receiver cannot stall it.
// An allocate starts at the rover, checks free blocks in turn and may split one;
// a free walks to its place, reads the block and merges it with its upper,
// then its lower neighbor; a free of address zero ends at once; a heap
// growth frees a new block at the break by that walk and restarts the
// search. done rises in the cycle after the last step. The walk reads one
// header per cycle from the header memory, so list length sets the rate.
// The user writes the limit register with limit_we and limit_data only
// while the block is idle; the block does not enforce it. No clearing pass.
`default_nettype none

module free_list_heap_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        kind,
    input  wire logic [flha_pkg::SIZE_W-1:0] size_bytes,
    input  wire logic [flha_pkg::IDX_W-1:0]  address,
    output logic                             done,
    output logic [flha_pkg::IDX_W-1:0]       address_res,
    output logic                             ok,
    input  wire logic                        limit_we,
    input  wire logic [flha_pkg::POS_W-1:0]  limit_data
);

    logic [flha_pkg::POS_W-1:0] limit_reg;
    flha_pkg::q_stat_t          q_stat;
    flha_pkg::req_t             push_req;
    flha_pkg::req_t             head;
    logic                       push;
    logic                       pop;

    // Heap limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= flha_pkg::HEAP_POS_MAX;
        else if (limit_we)
            limit_reg <= limit_data;
    end

    flha_front u_front (
        .start      (start),
        .kind       (kind),
        .size_bytes (size_bytes),
        .address    (address),
        .q_stat     (q_stat),
        .busy       (busy),
        .push       (push),
        .req        (push_req)
    );

    flha_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    flha_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit       (limit_reg),
        .q_stat      (q_stat),
        .head        (head),
        .pop         (pop),
        .done        (done),
        .address_res (address_res),
        .ok          (ok)
    );

`ifndef NO_ASSERTIONS
    // Queue cannot be full and empty at once
    a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");

    // A failed allocation returns null
    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (address_res == '0))
        else $error("failed allocation with non-null address");

    // Nothing is popped from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* rtl/flha_front.sv */
// ============================================================================
// flha_front
// Accepts requests and classifies them: byte count to units plus header.
// ============================================================================
`default_nettype none

module flha_front (
    input  wire logic                        start,
    input  wire logic                        kind,
    input  wire logic [flha_pkg::SIZE_W-1:0] size_bytes,
    input  wire logic [flha_pkg::IDX_W-1:0]  address,
    input  wire flha_pkg::q_stat_t           q_stat,
    output logic                             busy,
    output logic                             push,
    output flha_pkg::req_t                   req
);

    logic [flha_pkg::NU_W-1:0] units;

    // ceil(bytes / unit) plus one header unit
    always_comb
    begin
        units = flha_pkg::NU_W'(size_bytes[flha_pkg::SIZE_W-1:flha_pkg::UNIT_SHIFT])
              + flha_pkg::NU_W'(|size_bytes[flha_pkg::UNIT_SHIFT-1:0])
              + flha_pkg::NU_W'(1);
    end

    assign busy       = q_stat.full;
    assign push       = start && !q_stat.full;
    assign req.kind   = kind;
    assign req.nunits = units;
    assign req.bp     = address;

endmodule

`default_nettype wire

/* rtl/flha_queue.sv */
// ============================================================================
// flha_queue
// Two-entry request queue between the front and the back.
// ============================================================================
`default_nettype none

module flha_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire flha_pkg::req_t      push_req,
    input  wire logic                pop,
    output flha_pkg::req_t           head,
    output flha_pkg::q_stat_t        q_stat
);

    flha_pkg::req_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    // Occupancy
    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_req;
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg[1];
    assign q_stat.empty = (count_reg == 2'd0);

endmodule

`default_nettype wire

/* rtl/flha_back.sv */
// ============================================================================
// flha_back
// Walks the free list in header memory and carries out allocate and free.
// ============================================================================
`default_nettype none

module flha_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [flha_pkg::POS_W-1:0]  limit,
    input  wire flha_pkg::q_stat_t           q_stat,
    input  wire flha_pkg::req_t              head,
    output logic                             pop,
    output logic                             done,
    output logic [flha_pkg::IDX_W-1:0]       address_res,
    output logic                             ok
);

    localparam int PW = flha_pkg::POS_W;
    localparam int NW = flha_pkg::NU_W;
    localparam int SW = flha_pkg::STEP_W;
    localparam int DEPTH = flha_pkg::HEAP_UNITS;

    // Header memories
    logic [PW-1:0] next_mem [DEPTH];
    logic [PW-1:0] size_mem [DEPTH];
    logic [PW-1:0] next_q;
    logic [PW-1:0] size_q;

    flha_pkg::state_t state_reg, state_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] n_reg, n_next;
    logic [PW-1:0] bp_reg, bp_next;
    logic [PW-1:0] bsize_reg, bsize_next;
    logic [PW-1:0] bnext_reg, bnext_next;
    logic [NW-1:0] nunits_reg, nunits_next;
    logic [NW-1:0] p2_reg, p2_next;
    logic [SW-1:0] asteps_reg, asteps_next;
    logic [SW-1:0] rsteps_reg, rsteps_next;
    logic          from_alloc_reg, from_alloc_next;
    logic [PW-1:0] rover_reg, rover_next;
    logic [PW-1:0] sent_next_reg;
    logic [PW-1:0] brk_reg, brk_next;
    logic [PW-1:0] rd_pos, rd_pos_reg;
    logic          done_reg, done_next;
    logic          ok_reg, ok_next;
    logic [flha_pkg::IDX_W-1:0] res_reg, res_next;

    logic          wr_next_en, wr_size_en;
    logic [PW-1:0] wr_next_pos, wr_next_val, wr_size_pos, wr_size_val;

    logic [PW-1:0] eff_next, eff_size;
    logic [NW-1:0] nu, lim_ext;
    logic [PW-1:0] lim, diff;
    logic          grow_fail;
    logic [SW-1:0] asteps_inc, rsteps_inc;
    logic          walk_stop;
    logic [NW-1:0] bsum, psum;

    // Read data as the list sees it: sentinel, header or nothing
    always_comb
    begin
        if (rd_pos_reg == '0)
        begin
            eff_next = sent_next_reg;
            eff_size = '0;
        end
        else if (flha_pkg::pos_valid(rd_pos_reg))
        begin
            eff_next = next_q;
            eff_size = size_q;
        end
        else
        begin
            eff_next = '0;
            eff_size = '0;
        end
    end

    // Growth check
    always_comb
    begin
        nu        = (nunits_reg < flha_pkg::MIN_GROW_NU) ? flha_pkg::MIN_GROW_NU : nunits_reg;
        lim       = (limit < flha_pkg::HEAP_POS_MAX) ? limit : flha_pkg::HEAP_POS_MAX;
        lim_ext   = NW'(lim);
        grow_fail = (nu > lim_ext) || (NW'(brk_reg) > (lim_ext - nu));
    end

    assign asteps_inc = asteps_reg + SW'(1);
    assign rsteps_inc = rsteps_reg + SW'(1);
    assign diff       = eff_size - nunits_reg[PW-1:0];
    assign bsum       = NW'(bp_reg) + NW'(bsize_reg);
    assign psum       = NW'(p_reg) + NW'(eff_size);

    // Insertion point test of the release walk
    always_comb
    begin
        walk_stop = ((bp_reg > p_reg) && (bp_reg < eff_next))
                 || ((p_reg >= eff_next) && ((bp_reg > p_reg) || (bp_reg < eff_next)));
    end

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        p_next          = p_reg;
        prev_next       = prev_reg;
        n_next          = n_reg;
        bp_next         = bp_reg;
        bsize_next      = bsize_reg;
        bnext_next      = bnext_reg;
        nunits_next     = nunits_reg;
        p2_next         = p2_reg;
        asteps_next     = asteps_reg;
        rsteps_next     = rsteps_reg;
        from_alloc_next = from_alloc_reg;
        rover_next      = rover_reg;
        brk_next        = brk_reg;
        rd_pos          = p_reg;
        done_next       = 1'b0;
        ok_next         = ok_reg;
        res_next        = res_reg;
        pop             = 1'b0;
        wr_next_en      = 1'b0;
        wr_next_pos     = '0;
        wr_next_val     = '0;
        wr_size_en      = 1'b0;
        wr_size_pos     = '0;
        wr_size_val     = '0;

        case (state_reg)
            flha_pkg::ST_IDLE:
            begin
                rd_pos = rover_reg;
                if (!q_stat.empty)
                begin
                    pop         = 1'b1;
                    nunits_next = head.nunits;
                    bp_next     = PW'(head.bp);
                    if (head.kind == flha_pkg::KIND_FREE)
                    begin
                        if (head.bp == '0)
                        begin
                            done_next = 1'b1;
                            ok_next   = 1'b1;
                            res_next  = '0;
                        end
                        else
                        begin
                            from_alloc_next = 1'b0;
                            p_next          = rover_reg;
                            rsteps_next     = '0;
                            state_next      = flha_pkg::ST_R_WALK;
                        end
                    end
                    else
                    begin
                        prev_next   = rover_reg;
                        asteps_next = '0;
                        state_next  = flha_pkg::ST_A_FIRST;
                    end
                end
            end

            flha_pkg::ST_A_FIRST:
            begin
                p_next     = eff_next;
                rd_pos     = eff_next;
                state_next = flha_pkg::ST_A_CHECK;
            end

            flha_pkg::ST_A_CHECK:
            begin
                if (NW'(eff_size) >= nunits_reg)
                begin
                    if (NW'(eff_size) == nunits_reg)
                    begin
                        // exact fit: unlink
                        wr_next_en  = 1'b1;
                        wr_next_pos = prev_reg;
                        wr_next_val = eff_next;
                        rover_next  = prev_reg;
                        done_next   = 1'b1;
                        ok_next     = (p_reg != '0);
                        res_next    = p_reg[flha_pkg::IDX_W-1:0];
                        state_next  = flha_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // larger block: give up the tail
                        wr_size_en  = 1'b1;
                        wr_size_pos = p_reg;
                        wr_size_val = diff;
                        p2_next     = NW'(p_reg) + NW'(diff);
                        state_next  = flha_pkg::ST_A_SPLIT;
                    end
                end
                else if (p_reg == rover_reg)
                begin
                    if (grow_fail)
                    begin
                        done_next  = 1'b1;
                        ok_next    = 1'b0;
                        res_next   = '0;
                        state_next = flha_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // new block at the break, then free it
                        wr_size_en      = 1'b1;
                        wr_size_pos     = brk_reg + PW'(1);
                        wr_size_val     = nu[PW-1:0];
                        brk_next        = brk_reg + nu[PW-1:0];
                        bp_next         = brk_reg + PW'(1);
                        from_alloc_next = 1'b1;
                        p_next          = rover_reg;
                        rd_pos          = rover_reg;
                        rsteps_next     = '0;
                        state_next      = flha_pkg::ST_R_WALK;
                    end
                end
                else if (asteps_inc >= flha_pkg::STEP_CAP)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                    res_next   = '0;
                    state_next = flha_pkg::ST_IDLE;
                end
                else
                begin
                    asteps_next = asteps_inc;
                    prev_next   = p_reg;
                    p_next      = eff_next;
                    rd_pos      = eff_next;
                end
            end

            flha_pkg::ST_A_SPLIT:
            begin
                wr_size_en  = (p2_reg != '0) && (p2_reg <= NW'(flha_pkg::HEAP_POS_MAX));
                wr_size_pos = p2_reg[PW-1:0];
                wr_size_val = nunits_reg[PW-1:0];
                rover_next  = prev_reg;
                done_next   = 1'b1;
                ok_next     = 1'b1;
                res_next    = p2_reg[flha_pkg::IDX_W-1:0];
                state_next  = flha_pkg::ST_IDLE;
            end

            flha_pkg::ST_A_GROWN:
            begin
                if (asteps_inc >= flha_pkg::STEP_CAP)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                    res_next   = '0;
                    state_next = flha_pkg::ST_IDLE;
                end
                else
                begin
                    asteps_next = asteps_inc;
                    prev_next   = rover_reg;
                    rd_pos      = rover_reg;
                    state_next  = flha_pkg::ST_A_FIRST;
                end
            end

            flha_pkg::ST_R_WALK:
            begin
                if (walk_stop)
                begin
                    n_next     = eff_next;
                    rd_pos     = bp_reg;
                    state_next = flha_pkg::ST_R_B;
                end
                else if (rsteps_inc >= flha_pkg::STEP_CAP)
                begin
                    // runaway walk: leave the list alone
                    if (from_alloc_reg)
                        state_next = flha_pkg::ST_A_GROWN;
                    else
                    begin
                        done_next  = 1'b1;
                        ok_next    = 1'b1;
                        res_next   = '0;
                        state_next = flha_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    rsteps_next = rsteps_inc;
                    p_next      = eff_next;
                    rd_pos      = eff_next;
                end
            end

            flha_pkg::ST_R_B:
            begin
                bsize_next = eff_size;
                rd_pos     = n_reg;
                state_next = flha_pkg::ST_R_N;
            end

            flha_pkg::ST_R_N:
            begin
                // merge with upper neighbor
                wr_next_en  = 1'b1;
                wr_next_pos = bp_reg;
                if (bsum == NW'(n_reg))
                begin
                    bsize_next  = bsize_reg + eff_size;
                    bnext_next  = eff_next;
                    wr_size_en  = 1'b1;
                    wr_size_pos = bp_reg;
                    wr_size_val = bsize_reg + eff_size;
                    wr_next_val = eff_next;
                end
                else
                begin
                    bnext_next  = n_reg;
                    wr_next_val = n_reg;
                end
                rd_pos     = p_reg;
                state_next = flha_pkg::ST_R_P;
            end

            flha_pkg::ST_R_P:
            begin
                // merge with lower neighbor
                wr_next_en  = 1'b1;
                wr_next_pos = p_reg;
                if (psum == NW'(bp_reg))
                begin
                    wr_size_en  = 1'b1;
                    wr_size_pos = p_reg;
                    wr_size_val = eff_size + bsize_reg;
                    wr_next_val = bnext_reg;
                end
                else
                    wr_next_val = bp_reg;
                rover_next = p_reg;
                if (from_alloc_reg)
                    state_next = flha_pkg::ST_A_GROWN;
                else
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    res_next   = '0;
                    state_next = flha_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = flha_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flha_pkg::ST_IDLE;
            rover_reg     <= '0;
            sent_next_reg <= '0;
            brk_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rover_reg <= rover_next;
            brk_reg   <= brk_next;
            done_reg  <= done_next;
            if (wr_next_en && (wr_next_pos == '0))
                sent_next_reg <= wr_next_val;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        prev_reg       <= prev_next;
        n_reg          <= n_next;
        bp_reg         <= bp_next;
        bsize_reg      <= bsize_next;
        bnext_reg      <= bnext_next;
        nunits_reg     <= nunits_next;
        p2_reg         <= p2_next;
        asteps_reg     <= asteps_next;
        rsteps_reg     <= rsteps_next;
        from_alloc_reg <= from_alloc_next;
        rd_pos_reg     <= rd_pos;
        ok_reg         <= ok_next;
        res_reg        <= res_next;
    end

    // Header memories: one write and one read each per cycle
    always_ff @(posedge clk)
    begin
        if (wr_next_en && flha_pkg::pos_valid(wr_next_pos))
            next_mem[flha_pkg::pos_idx(wr_next_pos)] <= wr_next_val;
        next_q <= next_mem[flha_pkg::pos_idx(rd_pos)];
    end

    always_ff @(posedge clk)
    begin
        if (wr_size_en && flha_pkg::pos_valid(wr_size_pos))
            size_mem[flha_pkg::pos_idx(wr_size_pos)] <= wr_size_val;
        size_q <= size_mem[flha_pkg::pos_idx(rd_pos)];
    end

    assign done        = done_reg;
    assign ok          = ok_reg;
    assign address_res = res_reg;

endmodule

`default_nettype wire

/* tb/free_list_heap_allocator_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_list_heap_allocator_checker
// Watches the request, result and limit ports of the allocator, keeps its own
// copy of the free list and break, and compares every result with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             kind,
    input  logic [flha_pkg::SIZE_W-1:0]      size_bytes,
    input  logic [flha_pkg::IDX_W-1:0]       address,
    input  logic                             done,
    input  logic [flha_pkg::IDX_W-1:0]       address_res,
    input  logic                             ok,
    input  logic                             limit_we,
    input  logic [flha_pkg::POS_W-1:0]       limit_data,
    output int                               fail_count,
    output int                               outstanding
);

    localparam int unsigned UNITS     = flha_pkg::HEAP_UNITS;
    localparam int unsigned WALK_CAP  = 2 * UNITS + 4;
    localparam int unsigned FLD_MASK  = 2 * UNITS - 1;
    localparam int unsigned GROW_MIN  = flha_pkg::MIN_GROWTH;

    typedef struct {
        logic [flha_pkg::IDX_W-1:0] addr;
        logic                       ok;
    } alloc_result_t;

    // predicted heap state
    int unsigned   hdr_nxt [UNITS];
    int unsigned   hdr_sz  [UNITS];
    int unsigned   head_nxt;
    int unsigned   rover_pos;
    int unsigned   brk;
    bit            started;
    int unsigned   limit_reg;
    alloc_result_t pending_results [$];

    function automatic int unsigned get_next(int unsigned p);
        if (p == 0) return head_nxt;
        if (p - 1 < UNITS) return hdr_nxt[p - 1];
        return 0;
    endfunction

    function automatic int unsigned get_size(int unsigned p);
        if (p != 0 && p - 1 < UNITS) return hdr_sz[p - 1];
        return 0;
    endfunction

    function automatic void put_next(int unsigned p, int unsigned v);
        v &= FLD_MASK;
        if (p == 0) head_nxt = v;
        else if (p - 1 < UNITS) hdr_nxt[p - 1] = v;
    endfunction

    function automatic void put_size(int unsigned p, int unsigned v);
        if (p != 0 && p - 1 < UNITS) hdr_sz[p - 1] = v & FLD_MASK;
    endfunction

    // relink a block in address order, merging with both neighbors
    function automatic void link_block(int unsigned bp);
        int unsigned p;
        int unsigned n;
        int unsigned steps;
        p = rover_pos;
        steps = 0;
        if (bp == 0) return;
        forever
        begin
            n = get_next(p);
            if (bp > p && bp < n) break;
            if (p >= n && (bp > p || bp < n)) break;
            steps++;
            if (steps >= WALK_CAP) return;
            p = n;
        end
        if (bp + get_size(bp) == n)
        begin
            put_size(bp, get_size(bp) + get_size(n));
            put_next(bp, get_next(n));
        end
        else
            put_next(bp, n);
        if (p + get_size(p) == bp)
        begin
            put_size(p, get_size(p) + get_size(bp));
            put_next(p, get_next(bp));
        end
        else
            put_next(p, bp);
        rover_pos = p;
    endfunction

    function automatic bit extend_heap(int unsigned nunits);
        int unsigned nu;
        int unsigned lim;
        int unsigned pos;
        nu  = nunits < GROW_MIN ? GROW_MIN : nunits;
        lim = limit_reg < UNITS ? limit_reg : UNITS;
        if (nu > lim || brk > lim - nu) return 0;
        pos = brk + 1;
        put_size(pos, nu);
        brk += nu;
        link_block(pos);
        return 1;
    endfunction

    function automatic void open_list();
        if (!started)
        begin
            head_nxt  = 0;
            rover_pos = 0;
            started   = 1;
        end
    endfunction

    // next-fit search; returns the data position, 0 on failure
    function automatic int unsigned take_units(int unsigned nbytes);
        int unsigned nunits;
        int unsigned prev;
        int unsigned p;
        int unsigned s;
        int unsigned steps;
        nunits = (nbytes + 15) / 16 + 1;
        steps  = 0;
        open_list();
        prev = rover_pos;
        p    = get_next(prev);
        forever
        begin
            s = get_size(p);
            if (s >= nunits)
            begin
                if (s == nunits)
                    put_next(prev, get_next(p));
                else
                begin
                    put_size(p, s - nunits);
                    p += s - nunits;
                    put_size(p, nunits);
                end
                rover_pos = prev;
                return p;
            end
            if (p == rover_pos)
            begin
                if (!extend_heap(nunits)) return 0;
                p = rover_pos;
            end
            steps++;
            if (steps >= WALK_CAP) return 0;
            prev = p;
            p    = get_next(p);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t exp_r;
        int unsigned   p;
        if (!rst_n)
        begin
            head_nxt    = 0;
            rover_pos   = 0;
            brk         = 0;
            started     = 0;
            limit_reg   = 65536;
            fail_count  = 0;
            pending_results.delete();
            outstanding = 0;
        end
        else
        begin
            // compare a finished request with the oldest prediction
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result addr=%0d ok=%0b",
                                 $time, address_res, ok);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (exp_r.addr !== address_res || exp_r.ok !== ok)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp addr=%0d ok=%0b got addr=%0d ok=%0b",
                                     $time, exp_r.addr, exp_r.ok, address_res, ok);
                    end
                end
            end
            if (limit_we)
                limit_reg = 32'(limit_data);
            // predict an accepted request
            if (start && !busy)
            begin
                if (kind == flha_pkg::KIND_FREE)
                begin
                    open_list();
                    link_block(32'(address));
                    exp_r.addr = '0;
                    exp_r.ok   = 1'b1;
                end
                else
                begin
                    p = take_units(32'(size_bytes));
                    exp_r.addr = p[flha_pkg::IDX_W-1:0];
                    exp_r.ok   = p != 0;
                end
                pending_results.push_back(exp_r);
            end
            outstanding = pending_results.size();
        end
    end
endmodule

/* tb/free_list_heap_allocator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_list_heap_allocator_test
// Drives allocate and free requests through several limit settings and idle
// patterns; only blocks that were handed out are freed. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_test;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           kind;
    logic [flha_pkg::SIZE_W-1:0]    size_bytes;
    logic [flha_pkg::IDX_W-1:0]     address;
    logic                           done;
    logic [flha_pkg::IDX_W-1:0]     address_res;
    logic                           ok;
    logic                           limit_we;
    logic [flha_pkg::POS_W-1:0]     limit_data;
    int                             fail_count;
    int                             outstanding;
    int                             idle_pct;
    logic [flha_pkg::IDX_W-1:0]     live_blocks [$];

    free_list_heap_allocator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .size_bytes  (size_bytes),
        .address     (address),
        .done        (done),
        .address_res (address_res),
        .ok          (ok),
        .limit_we    (limit_we),
        .limit_data  (limit_data)
    );

    free_list_heap_allocator_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .size_bytes  (size_bytes),
        .address     (address),
        .done        (done),
        .address_res (address_res),
        .ok          (ok),
        .limit_we    (limit_we),
        .limit_data  (limit_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // track blocks handed out so frees only touch written headers
    always @(posedge clk)
    begin
        if (done && ok && address_res != '0)
            live_blocks.push_back(address_res);
    end

    // send one request and hold it until taken
    task automatic send_request(logic k, logic [flha_pkg::SIZE_W-1:0] sz,
                                logic [flha_pkg::IDX_W-1:0] ad);
        start      <= 1'b1;
        kind       <= k;
        size_bytes <= sz;
        address    <= ad;
        do @(posedge clk); while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic alloc_bytes(logic [flha_pkg::SIZE_W-1:0] sz);
        send_request(flha_pkg::KIND_ALLOC, sz, flha_pkg::IDX_W'($urandom));
    endtask

    task automatic free_live();
        int unsigned i;
        logic [flha_pkg::IDX_W-1:0] a;
        if (live_blocks.size() == 0)
            send_request(flha_pkg::KIND_FREE, '0, '0);
        else
        begin
            i = $urandom_range(live_blocks.size() - 1);
            a = live_blocks[i];
            live_blocks.delete(i);
            send_request(flha_pkg::KIND_FREE, '0, a);
        end
    endtask

    // drain all results, then write the limit
    task automatic set_limit(logic [flha_pkg::POS_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        limit_we   <= 1'b1;
        limit_data <= v;
        @(posedge clk);
        limit_we   <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 4)
                send_request(flha_pkg::KIND_FREE, flha_pkg::SIZE_W'($urandom), '0);
            else if (r < 48 && live_blocks.size() != 0)
                free_live();
            else
            begin
                r = $urandom_range(99);
                if (r < 78)
                    alloc_bytes(flha_pkg::SIZE_W'($urandom_range(0, 256)));
                else if (r < 95)
                    alloc_bytes(flha_pkg::SIZE_W'($urandom_range(0, 12000)));
                else
                    alloc_bytes(flha_pkg::SIZE_W'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = flha_pkg::KIND_ALLOC;
        size_bytes = '0;
        address    = '0;
        limit_we   = 1'b0;
        limit_data = '0;
        idle_pct   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-list free, size extremes, high addresses
        send_request(flha_pkg::KIND_FREE, '0, '0);
        alloc_bytes(flha_pkg::SIZE_W'(0));
        alloc_bytes(flha_pkg::SIZE_W'(1));
        alloc_bytes(flha_pkg::SIZE_W'(16));
        alloc_bytes(flha_pkg::SIZE_W'(17));
        alloc_bytes('1);
        alloc_bytes(flha_pkg::SIZE_W'(1048576));
        alloc_bytes(flha_pkg::SIZE_W'(60000 * 16));
        alloc_bytes(flha_pkg::SIZE_W'(65535 * 16));
        set_limit(flha_pkg::POS_W'(4096));
        alloc_bytes(flha_pkg::SIZE_W'(4095 * 16));
        alloc_bytes(flha_pkg::SIZE_W'(100000));
        set_limit('1);
        alloc_bytes(flha_pkg::SIZE_W'(20000));
        repeat (4) free_live();
        alloc_bytes(flha_pkg::SIZE_W'(0));

        // random phases over limits and idle patterns
        set_limit(flha_pkg::POS_W'(65536));
        idle_pct = 0;
        random_phase(300);
        set_limit(flha_pkg::POS_W'(4096));
        idle_pct = 85;
        random_phase(200);
        set_limit('1);
        idle_pct = 25;
        random_phase(300);
        set_limit(flha_pkg::POS_W'($urandom_range(4096, 65536)));
        idle_pct = 0;
        random_phase(200);
        set_limit(flha_pkg::POS_W'(65536));
        idle_pct = 85;
        random_phase(200);

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("free_list_heap_allocator_test OK");
        else
            $display("free_list_heap_allocator_test NOT OK");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("free_list_heap_allocator_test NOT OK");
        $finish;
    end
endmodule
